[rtl/lspd_pkg.sv]
package lspd_pkg;

  // store depth and derived widths
  localparam int MAX_SAMPLES = 40;
  localparam int CNT_W       = 7;
  localparam int SAMPLE_AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NUM_W       = 6;

  // packet framing constants
  localparam logic [7:0]       HDR0_BYTE      = 8'hAA;
  localparam logic [7:0]       HDR1_BYTE      = 8'h55;
  localparam logic [7:0]       TYPE_MAX       = 8'h01;
  localparam logic [7:0]       ZERO_PKT_COUNT = 8'h01;
  localparam logic [15:0]      XOR_SEED       = 16'h55AA;
  localparam logic [CNT_W-1:0] LIMIT_RESET    = CNT_W'(40);
  localparam logic [CNT_W-1:0] MAX_LIMIT      = CNT_W'(MAX_SAMPLES);
  localparam logic [7:0]       TALLY_SAT      = 8'd254;
  localparam logic [7:0]       TALLY_NEVER    = 8'd255;

  // result status codes
  typedef enum logic [2:0] {
    ST_SAMPLE     = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_TYPE   = 3'd2,
    ST_ZERO_COUNT = 3'd3,
    ST_BAD_COUNT  = 3'd4,
    ST_ANGLE_BIT  = 3'd5,
    ST_CHECKSUM   = 3'd6
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    hold;
    logic    xor_word;
    logic    set_count;
    logic    set_first;
    logic    set_final;
    logic    store;
    logic    restart;
    logic    err_load;
    status_t err_code;
    logic    good;
    logic    drain_read;
    logic    drain_load;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_hdr0;
    logic is_hdr1;
    logic type_ok;
    logic angle_lsb;
    logic kind_bad;
    logic range_bad;
    logic last_sample;
    logic xor_ok;
    logic drain_last;
    logic out_busy;
  } dp_status_t;

endpackage

[rtl/lidar_scan_packet_deframer.sv]
// Scan packet deframer for a serial lidar link.
// Input stream (s_*): one received byte per item in s_tdata. The parser
// hunts for the AA 55 header, checks type, count, angle bits and the 16-bit
// XOR checksum, and buffers the sample words of the packet.
// Output stream (m_*): a good packet gives one item per sample, tlast on the
// final one; any framing error gives a single item with tlast set and the
// error code in tuser. The erroring byte is dropped and hunting restarts.
// Config (APB): sample_limit at address 0, reset 40, write only while idle.
// Throughput: one byte per cycle while parsing. An error item shows on
// m_tvalid the cycle after its byte. A good run gives its samples in turn,
// each by a registered read of the sample memory followed by the output
// load, which waits while the output is stalled.
// s_tready is low during a run and whenever the output register holds an
// item that the receiver stalls; the block holds its output until taken.
// Reset: header hunt, sample_limit 40, fail count 255 (never good), output
// empty. The sample memory is not cleared; only written entries are read.
module lidar_scan_packet_deframer
  import lspd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // s_tdata: rx_byte[7:0]
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // m_tdata: distance_raw[15:0], sample_number[21:16], start_angle[36:22],
  //          end_angle[51:37], zero_packet[52], fail_count[60:53], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,
  // m_tuser: status[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_cmd_t        cmd;
  dp_status_t       sts;
  logic [CNT_W-1:0] sample_limit;
  logic             draining;

  lspd_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_limit (sample_limit)
  );

  lspd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .sts      (sts),
    .in_ready (s_tready),
    .draining (draining),
    .cmd      (cmd)
  );

  lspd_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (s_tdata),
    .cmd          (cmd),
    .sample_limit (sample_limit),
    .m_tready     (m_tready),
    .sts          (sts),
    .m_tvalid     (m_tvalid),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

  // error items stand alone
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_SAMPLE) |-> m_tlast)
    else $error("error item without tlast");

  // sample items come from a good packet
  a_sample_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_SAMPLE) |-> (m_tdata[60:53] == 8'd0))
    else $error("sample item with nonzero fail count");

  // no byte taken while a stalled item waits
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("byte accepted while output stalled");

  // no byte taken during a sample run
  a_no_take_in_run: assert property (@(posedge clk) disable iff (rst)
    draining |-> !s_tready)
    else $error("byte accepted during sample run");

endmodule

[rtl/lspd_regs.sv]
module lspd_regs
  import lspd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CNT_W-1:0] sample_limit
);

  localparam logic REG_SAMPLE_LIMIT = 1'b0;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_SAMPLE_LIMIT);

  // sample limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      sample_limit <= pwdata[CNT_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SAMPLE_LIMIT) begin
      prdata = {{(32-CNT_W){1'b0}}, sample_limit};
    end
  end

endmodule

[rtl/lspd_datapath.sv]
module lspd_datapath
  import lspd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       rx_byte,
  input  ctrl_cmd_t        cmd,
  input  logic [CNT_W-1:0] sample_limit,
  input  logic             m_tready,
  output dp_status_t       sts,
  output logic             m_tvalid,
  output logic [63:0]      m_tdata,
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);

  logic [7:0]           held_byte;
  logic [15:0]          running_xor;
  logic                 packet_kind;
  logic [CNT_W-1:0]     sample_total;
  logic [CNT_W-1:0]     samples_seen;
  logic [14:0]          first_angle;
  logic [14:0]          final_angle;
  logic [7:0]           failure_tally;
  logic [SAMPLE_AW-1:0] drain_idx;
  logic [15:0]          rd_data;
  logic [15:0]          sample_mem [MAX_SAMPLES];

  logic [15:0]      word;
  logic [15:0]      xor_upd;
  logic [CNT_W-1:0] eff_limit;
  logic [7:0]       tally_err;

  // output register
  status_t          out_status;
  logic [15:0]      out_dist;
  logic [NUM_W-1:0] out_num;
  logic [14:0]      out_start;
  logic [14:0]      out_end;
  logic             out_kind;
  logic [7:0]       out_fail;
  logic             out_last;

  assign word      = {rx_byte, held_byte};
  assign xor_upd   = running_xor ^ word;
  assign eff_limit = (sample_limit > MAX_LIMIT) ? MAX_LIMIT : sample_limit;
  assign tally_err = (failure_tally < TALLY_SAT) ? failure_tally + 8'd1 : failure_tally;

  // status toward the controller
  always_comb begin
    sts.is_hdr0     = (rx_byte == HDR0_BYTE);
    sts.is_hdr1     = (rx_byte == HDR1_BYTE);
    sts.type_ok     = (rx_byte <= TYPE_MAX);
    sts.angle_lsb   = rx_byte[0];
    sts.kind_bad    = held_byte[0] && (rx_byte != ZERO_PKT_COUNT);
    sts.range_bad   = (rx_byte == 8'd0) || (rx_byte > {{(8-CNT_W){1'b0}}, eff_limit});
    sts.last_sample = ((samples_seen + CNT_W'(1)) == sample_total);
    sts.xor_ok      = (xor_upd == 16'd0);
    sts.drain_last  = ((CNT_W'(drain_idx) + CNT_W'(1)) == sample_total);
    sts.out_busy    = m_tvalid && !m_tready;
  end

  // parse registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte     <= '0;
      running_xor   <= XOR_SEED;
      packet_kind   <= 1'b0;
      sample_total  <= '0;
      samples_seen  <= '0;
      first_angle   <= '0;
      final_angle   <= '0;
      failure_tally <= TALLY_NEVER;
      drain_idx     <= '0;
    end else begin
      if (cmd.hold) begin
        held_byte <= rx_byte;
      end
      if (cmd.restart) begin
        running_xor  <= XOR_SEED;
        samples_seen <= '0;
      end else begin
        if (cmd.xor_word) begin
          running_xor <= xor_upd;
        end
        if (cmd.store) begin
          samples_seen <= samples_seen + CNT_W'(1);
        end
      end
      if (cmd.set_count) begin
        packet_kind  <= held_byte[0];
        sample_total <= rx_byte[CNT_W-1:0];
      end
      if (cmd.set_first) begin
        first_angle <= word[15:1];
      end
      if (cmd.set_final) begin
        final_angle <= word[15:1];
      end
      if (cmd.err_load) begin
        failure_tally <= tally_err;
      end else if (cmd.good) begin
        failure_tally <= '0;
      end
      if (cmd.good) begin
        drain_idx <= '0;
      end else if (cmd.drain_load) begin
        drain_idx <= drain_idx + SAMPLE_AW'(1);
      end
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      sample_mem[samples_seen[SAMPLE_AW-1:0]] <= word;
    end
    if (cmd.drain_read) begin
      rd_data <= sample_mem[drain_idx];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.err_load || cmd.drain_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.err_load) begin
      out_status <= cmd.err_code;
      out_dist   <= '0;
      out_num    <= '0;
      out_start  <= '0;
      out_end    <= '0;
      out_kind   <= 1'b0;
      out_fail   <= tally_err;
      out_last   <= 1'b1;
    end else if (cmd.drain_load) begin
      out_status <= ST_SAMPLE;
      out_dist   <= rd_data;
      out_num    <= NUM_W'(drain_idx);
      out_start  <= first_angle;
      out_end    <= final_angle;
      out_kind   <= packet_kind;
      out_fail   <= '0;
      out_last   <= sts.drain_last;
    end
  end

  assign m_tdata = {3'b000, out_fail, out_kind, out_end, out_start, out_num, out_dist};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule

[rtl/lspd_ctrl.sv]
module lspd_ctrl
  import lspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t sts,
  output logic       in_ready,
  output logic       draining,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_HDR0, S_HDR1, S_TYPE, S_COUNT,
    S_SA_LO, S_SA_HI, S_EA_LO, S_EA_HI,
    S_CK_LO, S_CK_HI, S_SMP_LO, S_SMP_HI,
    S_DRAIN_RD, S_DRAIN_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  logic    accept;
  logic    err;
  status_t err_code;

  assign draining = (state == S_DRAIN_RD) || (state == S_DRAIN_WAIT);
  assign in_ready = !draining && !sts.out_busy;
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    err        = 1'b0;
    err_code   = ST_SAMPLE;
    unique case (state)
      S_HDR0: begin
        if (accept) begin
          if (sts.is_hdr0) state_next = S_HDR1;
          else begin err = 1'b1; err_code = ST_BAD_HEADER; end
        end
      end
      S_HDR1: begin
        if (accept) begin
          if (sts.is_hdr1) state_next = S_TYPE;
          else begin err = 1'b1; err_code = ST_BAD_HEADER; end
        end
      end
      S_TYPE: begin
        if (accept) begin
          if (sts.type_ok) begin
            cmd.hold   = 1'b1;
            state_next = S_COUNT;
          end else begin
            err = 1'b1; err_code = ST_BAD_TYPE;
          end
        end
      end
      S_COUNT: begin
        if (accept) begin
          if (sts.kind_bad) begin
            err = 1'b1; err_code = ST_ZERO_COUNT;
          end else if (sts.range_bad) begin
            err = 1'b1; err_code = ST_BAD_COUNT;
          end else begin
            cmd.xor_word  = 1'b1;
            cmd.set_count = 1'b1;
            state_next    = S_SA_LO;
          end
        end
      end
      S_SA_LO, S_EA_LO: begin
        if (accept) begin
          cmd.hold = 1'b1;
          if (!sts.angle_lsb) begin
            err = 1'b1; err_code = ST_ANGLE_BIT;
          end else begin
            state_next = (state == S_SA_LO) ? S_SA_HI : S_EA_HI;
          end
        end
      end
      S_SA_HI: begin
        if (accept) begin
          cmd.xor_word  = 1'b1;
          cmd.set_first = 1'b1;
          state_next    = S_EA_LO;
        end
      end
      S_EA_HI: begin
        if (accept) begin
          cmd.xor_word  = 1'b1;
          cmd.set_final = 1'b1;
          state_next    = S_CK_LO;
        end
      end
      S_CK_LO: begin
        if (accept) begin
          cmd.hold   = 1'b1;
          state_next = S_CK_HI;
        end
      end
      S_CK_HI: begin
        if (accept) begin
          cmd.xor_word = 1'b1;
          state_next   = S_SMP_LO;
        end
      end
      S_SMP_LO: begin
        if (accept) begin
          cmd.hold   = 1'b1;
          state_next = S_SMP_HI;
        end
      end
      S_SMP_HI: begin
        if (accept) begin
          cmd.xor_word = 1'b1;
          cmd.store    = 1'b1;
          if (!sts.last_sample) begin
            state_next = S_SMP_LO;
          end else if (sts.xor_ok) begin
            // good packet: start the sample run
            cmd.restart = 1'b1;
            cmd.good    = 1'b1;
            state_next  = S_DRAIN_RD;
          end else begin
            err = 1'b1; err_code = ST_CHECKSUM;
          end
        end
      end
      S_DRAIN_RD: begin
        cmd.drain_read = 1'b1;
        state_next     = S_DRAIN_WAIT;
      end
      S_DRAIN_WAIT: begin
        if (!sts.out_busy) begin
          cmd.drain_load = 1'b1;
          state_next     = sts.drain_last ? S_HDR0 : S_DRAIN_RD;
        end
      end
      default: begin
        state_next = S_HDR0;
      end
    endcase
    // any error: one status result, back to header hunt
    if (err) begin
      cmd.err_load = 1'b1;
      cmd.err_code = err_code;
      cmd.restart  = 1'b1;
      state_next   = S_HDR0;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HDR0;
    end else begin
      state <= state_next;
    end
  end

endmodule

[tb/lidar_scan_packet_deframer_checker.sv]
`timescale 1ns / 100ps

module lidar_scan_packet_deframer_checker
  import lspd_pkg::*;
#(
  parameter logic [2:0] LIMIT_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          pending,
  output int          errors,
  output int          good_runs,
  output int          sample_items,
  output int          fault_items
);

  // m_tdata layout, highest field first
  typedef struct packed {
    logic [2:0]       fill;
    logic [7:0]       fail;
    logic             zero_pkt;
    logic [14:0]      end_ang;
    logic [14:0]      start_ang;
    logic [NUM_W-1:0] num;
    logic [15:0]      distance;
  } result_bits_t;

  typedef struct packed {
    status_t      code;
    logic         tlast;
    result_bits_t bits;
  } deframed_t;

  deframed_t deframed_q[$];

  // parser state mirrored from the block
  logic [7:0]       phase;
  logic [7:0]       held;
  logic [15:0]      xsum;
  logic             kind;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] seen;
  logic [14:0]      ang_first;
  logic [14:0]      ang_final;
  logic [15:0]      words [MAX_SAMPLES];
  logic [7:0]       tally;
  logic [CNT_W-1:0] limit_reg;

  int err_n;
  int run_n;
  int samp_n;
  int fault_n;

  function automatic string show_result(deframed_t r);
    return $sformatf({"status %0d dist %h num %0d start %h end %h",
                      " zero %0b fail %0d fill %0d last %0b"},
                     r.code, r.bits.distance, r.bits.num, r.bits.start_ang, r.bits.end_ang,
                     r.bits.zero_pkt, r.bits.fail, r.bits.fill, r.tlast);
  endfunction

  task automatic restart_hunt();
    phase = 8'd0;
    xsum  = XOR_SEED;
    seen  = '0;
  endtask

  // one status item, fail tally bumped unless saturated or never good
  task automatic push_fault(input status_t code);
    deframed_t r;
    if (tally < TALLY_SAT) tally = tally + 8'd1;
    restart_hunt();
    r = '0;
    r.code = code;
    r.tlast = 1'b1;
    r.bits.fail = tally;
    deframed_q.push_back(r);
  endtask

  // good packet: every buffered sample goes out, tlast on the final one
  task automatic push_run();
    deframed_t r;
    int i;
    restart_hunt();
    tally = 8'd0;
    for (i = 0; i < total; i++) begin
      r = '0;
      r.code = ST_SAMPLE;
      r.tlast = (i + 1 == total);
      r.bits.distance = words[i];
      r.bits.num = i[NUM_W-1:0];
      r.bits.start_ang = ang_first;
      r.bits.end_ang = ang_final;
      r.bits.zero_pkt = kind;
      r.bits.fail = tally;
      deframed_q.push_back(r);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] w;
    int lim;
    w = {b, held};
    lim = (limit_reg > MAX_LIMIT) ? MAX_SAMPLES : int'(limit_reg);
    case (phase)
      8'd0: begin
        if (b != HDR0_BYTE) push_fault(ST_BAD_HEADER);
        else phase = 8'd1;
      end
      8'd1: begin
        if (b != HDR1_BYTE) push_fault(ST_BAD_HEADER);
        else phase = 8'd2;
      end
      8'd2: begin
        if (b > TYPE_MAX) begin
          push_fault(ST_BAD_TYPE);
        end else begin
          held = b;
          phase = 8'd3;
        end
      end
      8'd3: begin
        xsum = xsum ^ w;
        kind = held[0];
        if (kind && b != ZERO_PKT_COUNT) begin
          push_fault(ST_ZERO_COUNT);
        end else if (b == 8'd0 || b > lim) begin
          push_fault(ST_BAD_COUNT);
        end else begin
          total = b[CNT_W-1:0];
          phase = 8'd4;
        end
      end
      8'd4, 8'd6: begin
        held = b;
        if (!b[0]) push_fault(ST_ANGLE_BIT);
        else phase = phase + 8'd1;
      end
      8'd5: begin
        xsum = xsum ^ w;
        ang_first = w[15:1];
        phase = 8'd6;
      end
      8'd7: begin
        xsum = xsum ^ w;
        ang_final = w[15:1];
        phase = 8'd8;
      end
      8'd8: begin
        held = b;
        phase = 8'd9;
      end
      8'd9: begin
        xsum = xsum ^ w;
        phase = 8'd10;
      end
      default: begin
        // sample bytes: low byte held, high byte completes the word
        if (!phase[0]) begin
          held = b;
          phase = phase + 8'd1;
        end else begin
          xsum = xsum ^ w;
          words[seen] = w;
          seen = seen + 1'b1;
          phase = phase + 8'd1;
          if (seen == total) begin
            if (xsum != 16'd0) push_fault(ST_CHECKSUM);
            else push_run();
          end
        end
      end
    endcase
  endtask

  task automatic check_result();
    deframed_t act;
    deframed_t want;
    act.code = status_t'(m_tuser);
    act.tlast = m_tlast;
    act.bits = m_tdata;
    if (act.code == ST_SAMPLE) begin
      samp_n++;
      if (m_tlast) run_n++;
    end else begin
      fault_n++;
    end
    if (deframed_q.size() == 0) begin
      err_n++;
      $display("%0t: unexpected item: %s", $time, show_result(act));
    end else begin
      want = deframed_q.pop_front();
      if (act !== want) begin
        err_n++;
        $display("%0t: item mismatch", $time);
        $display("  expected %s", show_result(want));
        $display("  actual   %s", show_result(act));
      end
    end
  endtask

  initial begin
    err_n = 0;
    run_n = 0;
    samp_n = 0;
    fault_n = 0;
  end

  // watch both streams and the register port
  always @(posedge clk) begin
    if (rst) begin
      restart_hunt();
      held = 8'd0;
      kind = 1'b0;
      total = '0;
      ang_first = '0;
      ang_final = '0;
      tally = TALLY_NEVER;
      limit_reg = LIMIT_RESET;
      deframed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        limit_reg = pwdata[CNT_W-1:0];
      if (s_tvalid && s_tready) parse_byte(s_tdata);
      if (m_tvalid && m_tready) check_result();
    end
    pending <= deframed_q.size();
    errors <= err_n;
    good_runs <= run_n;
    sample_items <= samp_n;
    fault_items <= fault_n;
  end

endmodule

[tb/lidar_scan_packet_deframer_tb.sv]
`timescale 1ns / 100ps

module lidar_scan_packet_deframer_tb;
  import lspd_pkg::*;

  localparam int         HALF_PERIOD       = 6;
  localparam int         RESET_CYCLES      = 6;
  localparam int         SETTLE_CYCLES     = 10;
  localparam int         STALL_LIMIT       = 3000;
  localparam int         LONG_HOLD         = 400;
  localparam int         PHASE_BYTES       = 20;
  localparam logic [2:0] ADDR_SAMPLE_LIMIT = 3'd0;

  // ways a generated packet can be spoiled
  typedef enum int {
    CLEAN,
    BAD_SYNC,
    BAD_TYPE,
    BAD_ZERO_COUNT,
    BAD_RANGE,
    BAD_START,
    BAD_END,
    BAD_SUM
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int results_due;
  int check_errors;
  int good_runs;
  int sample_items;
  int fault_items;

  int bytes_sent = 0;
  int limit_now = 40;
  int hold_reqs = 0;
  int holds_done = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;
  bit holding = 1'b0;

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  lidar_scan_packet_deframer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lidar_scan_packet_deframer_checker #(
    .LIMIT_ADDR (ADDR_SAMPLE_LIMIT)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .pending      (results_due),
    .errors       (check_errors),
    .good_runs    (good_runs),
    .sample_items (sample_items),
    .fault_items  (fault_items)
  );

  // receiver: ready stretches, short and long stalls, one long hold on request
  initial begin
    int pick;
    forever begin
      if (hold_reqs != holds_done) begin
        m_tready <= 1'b0;
        holding = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
        holds_done++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          m_tready <= 1'b1;
          repeat ($urandom_range(20, 80)) @(posedge clk);
        end else if (pick < 90) begin
          m_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
          m_tready <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat ($urandom_range(10, 30)) @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int next_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else if (r < 98) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  // mostly random words, now and then the extremes
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    s_tdata <= b;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    gap = next_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // bytes that never start a header
  task automatic send_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = $urandom_range(0, 255);
      if (b == HDR0_BYTE) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic send_packet(input logic kind_in, input int count, input flaw_t flaw);
    logic [7:0]  type_b;
    logic [7:0]  count_b;
    logic [7:0]  b;
    logic [15:0] sa;
    logic [15:0] ea;
    logic [15:0] cs;
    logic [15:0] samp[$];
    int n;
    int i;
    type_b = {7'd0, kind_in};
    count_b = count[7:0];
    sa = pick_word() | 16'h0001;
    ea = pick_word() | 16'h0001;
    n = (flaw == CLEAN || flaw == BAD_SUM) ? count : 0;
    for (i = 0; i < n; i++) samp.push_back(pick_word());
    // checksum word chosen so the running xor ends at zero
    cs = XOR_SEED ^ {count_b, type_b} ^ sa ^ ea;
    for (i = 0; i < n; i++) cs = cs ^ samp[i];
    case (flaw)
      BAD_TYPE:  type_b = $urandom_range(2, 255);
      BAD_START: sa[0] = 1'b0;
      BAD_END:   ea[0] = 1'b0;
      BAD_SUM:   cs = cs ^ (16'h0001 << $urandom_range(0, 15));
      default: ;
    endcase
    send_byte(HDR0_BYTE);
    if (flaw == BAD_SYNC) begin
      b = $urandom_range(0, 255);
      if (b == HDR1_BYTE) b = 8'h00;
      send_byte(b);
      return;
    end
    send_byte(HDR1_BYTE);
    send_byte(type_b);
    if (flaw == BAD_TYPE) return;
    send_byte(count_b);
    if (flaw == BAD_ZERO_COUNT || flaw == BAD_RANGE) return;
    send_byte(sa[7:0]);
    if (flaw == BAD_START) return;
    send_byte(sa[15:8]);
    send_byte(ea[7:0]);
    if (flaw == BAD_END) return;
    send_byte(ea[15:8]);
    send_byte(cs[7:0]);
    send_byte(cs[15:8]);
    for (i = 0; i < n; i++) begin
      send_byte(samp[i][7:0]);
      send_byte(samp[i][15:8]);
    end
  endtask

  // well-formed packets with random content, about a third spoiled
  task automatic send_random_packet();
    int eff;
    int count;
    logic kind;
    flaw_t flaw;
    eff = (limit_now > MAX_SAMPLES) ? MAX_SAMPLES : limit_now;
    steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 3));
    kind = ($urandom_range(0, 4) == 0);
    if (kind) count = 1;
    else if ($urandom_range(0, 9) == 0) count = eff;
    else count = $urandom_range(1, (eff < 6) ? eff : 6);
    flaw = CLEAN;
    if ($urandom_range(0, 99) >= 70) flaw = flaw_t'($urandom_range(BAD_SYNC, BAD_SUM));
    if (flaw == BAD_ZERO_COUNT) begin
      kind = 1'b1;
      count = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(2, 255);
    end else if (flaw == BAD_RANGE) begin
      kind = 1'b0;
      case ($urandom_range(0, 2))
        0: count = 0;
        1: count = eff + 1;
        default: count = $urandom_range(eff + 1, 255);
      endcase
    end
    send_packet(kind, count, flaw);
  endtask

  // stop sending and wait until every result is out
  task automatic drain();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sample_limit(input int v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_SAMPLE_LIMIT;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_now = v;
  endtask

  initial begin
    int start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // header hunting and type errors before any good packet
    send_byte(8'h00);
    send_byte(8'hFF);
    send_packet(1'b0, 3, BAD_SYNC);
    send_byte(HDR0_BYTE);
    send_byte(HDR0_BYTE);
    send_byte(HDR0_BYTE);
    send_byte(HDR1_BYTE);
    send_byte(8'h02);
    send_byte(HDR0_BYTE);
    send_byte(HDR1_BYTE);
    send_byte(8'hFF);

    // first good packet is a zero packet, then count, angle and checksum errors
    send_packet(1'b1, 1, CLEAN);
    send_packet(1'b1, 2, BAD_ZERO_COUNT);
    send_packet(1'b1, 0, BAD_ZERO_COUNT);
    send_packet(1'b0, 0, BAD_RANGE);
    send_packet(1'b0, 41, BAD_RANGE);
    send_packet(1'b0, 2, BAD_START);
    send_packet(1'b0, 2, BAD_END);
    send_packet(1'b0, 3, BAD_SUM);

    // smallest limit
    set_sample_limit(1);
    send_packet(1'b0, 1, CLEAN);
    send_packet(1'b0, 2, BAD_RANGE);

    // limit above the store depth acts as the depth; receiver held off meanwhile
    set_sample_limit(64);
    hold_reqs++;
    while (!holding) @(posedge clk);
    send_packet(1'b0, 6, CLEAN);
    send_packet(1'b0, 41, BAD_RANGE);

    // random packets at a small limit
    set_sample_limit($urandom_range(2, 8));
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) send_random_packet();
    steady = 1'b0;
    drain();

    $display("covered %0d bytes at sample limits 40, 1, 64 and %0d: %0d good packets, %0d samples",
             bytes_sent, limit_now, good_runs, sample_items);
    $display("plus %0d error items over header, type, count, angle bit and checksum",
             fault_items);
    if (check_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[lidar_scan_packet_deframer.f]
rtl/lspd_pkg.sv
rtl/lspd_regs.sv
rtl/lspd_datapath.sv
rtl/lspd_ctrl.sv
rtl/lidar_scan_packet_deframer.sv
tb/lidar_scan_packet_deframer_checker.sv
tb/lidar_scan_packet_deframer_tb.sv
